// ===== hdl/lfu_pkg.sv =====
// Shared constants, types and codes for the LFU cache with LRU tie-break.
`timescale 1ns / 1ps
package lfu_pkg;

  // Geometry
  localparam int ENTRIES     = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W       = $clog2(ENTRIES + 1);

  // Field widths fixed by the interface
  localparam int KEY_W = 32;
  localparam int VAL_W = 31;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0]       CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [IDX_W-1:0]       IDX_LAST  = IDX_W'(ENTRIES - 1);

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // One stored entry (key, value and use count share one memory word)
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
    logic [COUNT_WIDTH-1:0]  count;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic                    hit;
    logic [VAL_W-1:0]        read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

// ===== hdl/lfu_if.sv =====
// Channel interfaces: request, result and capacity write.
`timescale 1ns / 1ps

interface lfu_in_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [KEY_W-1:0] key;
  logic [VAL_W-1:0]        write_value;

  modport source (output valid, operation, key, write_value, input ready);
  modport sink   (input valid, operation, key, write_value, output ready);
endinterface

interface lfu_out_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [VAL_W-1:0]        read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/lfu_ctrl.sv =====
// Sequencer: accept a request, run the entry scan, then commit the update.
`timescale 1ns / 1ps
module lfu_ctrl import lfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/lfu_dpath.sv =====
// Datapath: entry memory, valid bits, recency ranks, scan registers and result register.
`timescale 1ns / 1ps
module lfu_dpath import lfu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // request payload
  input  logic                    in_operation,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0]        in_write_value,
  // capacity write
  input  logic                    cfg_wr,
  input  logic [CAP_W-1:0]        cfg_data,
  // control
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts,
  // result
  output logic                    out_valid,
  input  logic                    out_ready,
  output res_t                    out_res
);

  // Entry storage
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [OCC_W-1:0]   occ_r;
  logic [CAP_W-1:0]   cap_r;

  // Latched request
  logic                    op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [VAL_W-1:0]        wv_r;

  // Scan pipeline
  logic             iss_r;
  logic [IDX_W-1:0] addr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  entry_t           rd_word_r;

  // Scan findings
  logic                    hit_found_r;
  logic [IDX_W-1:0]        hit_slot_r;
  logic [VAL_W-1:0]        hit_val_r;
  logic [COUNT_WIDTH-1:0]  hit_cnt_r;
  logic [IDX_W-1:0]        hit_rank_r;
  logic                    free_found_r;
  logic [IDX_W-1:0]        free_slot_r;
  logic                    vic_found_r;
  logic [IDX_W-1:0]        vic_slot_r;
  logic [COUNT_WIDTH-1:0]  vic_cnt_r;
  logic [IDX_W-1:0]        vic_rank_r;
  logic signed [KEY_W-1:0] vic_key_r;

  // Result register
  logic out_vld_r;
  res_t res_r;

  // Commit decisions
  logic [OCC_W-1:0] cap_eff;
  logic             is_put;
  logic             do_write;
  logic             set_valid;
  logic             age_all;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] thr;
  logic [OCC_W-1:0] occ_nxt;
  entry_t           wr_word;
  res_t             res_nxt;

  // Scan compare on the entry now out of memory
  logic       cur_valid;
  logic [IDX_W-1:0] cur_rank;
  logic       cur_match;
  logic       cur_free;
  logic       cur_better;

  assign cap_eff = (32'(cap_r) > 32'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(cap_r);
  assign is_put  = (op_r == OP_PUT);

  assign cur_valid  = valid_r[rd_idx_r];
  assign cur_rank   = rank_r[rd_idx_r];
  assign cur_match  = rd_vld_r && cur_valid && (rd_word_r.key == key_r) && !hit_found_r;
  assign cur_free   = rd_vld_r && !cur_valid && !free_found_r;
  assign cur_better = rd_vld_r && cur_valid &&
                      (!vic_found_r || (rd_word_r.count < vic_cnt_r) ||
                       ((rd_word_r.count == vic_cnt_r) && (cur_rank > vic_rank_r)));

  assign sts.scan_done = rd_vld_r && (rd_idx_r == IDX_LAST);
  assign sts.out_free  = !out_vld_r || out_ready;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_data;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_operation;
      key_r <= in_key;
      wv_r  <= in_write_value;
    end
  end

  // Address sequencer for the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= iss_r;
      if (cmd.start) begin
        iss_r <= 1'b1;
      end else if (iss_r && (addr_r == IDX_LAST)) begin
        iss_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_r <= '0;
    end else if (iss_r) begin
      addr_r <= addr_r + 1'b1;
    end
    rd_idx_r <= addr_r;
  end

  // Entry memory: one read port for the scan, one write port for commit
  always_ff @(posedge clk) begin
    if (iss_r) begin
      rd_word_r <= mem[addr_r];
    end
    if (cmd.commit && do_write) begin
      mem[slot] <= wr_word;
    end
  end

  // Scan findings: key match, first free slot, victim candidate
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
    end else begin
      if (cur_match) begin
        hit_found_r <= 1'b1;
        hit_slot_r  <= rd_idx_r;
        hit_val_r   <= rd_word_r.value;
        hit_cnt_r   <= rd_word_r.count;
        hit_rank_r  <= cur_rank;
      end
      if (cur_free) begin
        free_found_r <= 1'b1;
        free_slot_r  <= rd_idx_r;
      end
      if (cur_better) begin
        vic_found_r <= 1'b1;
        vic_slot_r  <= rd_idx_r;
        vic_cnt_r   <= rd_word_r.count;
        vic_rank_r  <= cur_rank;
        vic_key_r   <= rd_word_r.key;
      end
    end
  end

  // Commit: pick the slot to touch and the result to report
  always_comb begin
    do_write  = 1'b0;
    set_valid = 1'b0;
    age_all   = 1'b0;
    slot      = hit_slot_r;
    thr       = hit_rank_r;
    occ_nxt   = occ_r;
    wr_word.key   = key_r;
    wr_word.value = wv_r;
    wr_word.count = COUNT_WIDTH'(1);
    res_nxt   = '0;
    if (is_put && (cap_eff == '0)) begin
      // puts disabled: no change, all-zero result
      do_write = 1'b0;
    end else if (hit_found_r) begin
      do_write      = 1'b1;
      wr_word.value = is_put ? wv_r : hit_val_r;
      wr_word.count = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
      res_nxt.hit        = 1'b1;
      res_nxt.read_value = is_put ? '0 : hit_val_r;
    end else if (is_put) begin
      do_write = 1'b1;
      if ((occ_r < cap_eff) || !vic_found_r) begin
        // insert into the first free slot; every valid entry ages
        slot      = free_slot_r;
        set_valid = 1'b1;
        age_all   = 1'b1;
        occ_nxt   = OCC_W'(occ_r + 1'b1);
      end else begin
        // replace the victim in place
        slot = vic_slot_r;
        thr  = vic_rank_r;
        res_nxt.evicted     = 1'b1;
        res_nxt.evicted_key = vic_key_r;
      end
    end
  end

  // Valid bits, occupancy and recency ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (cmd.commit) begin
      if (set_valid) valid_r[slot] <= 1'b1;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && (age_all || (rank_r[i] < thr))) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/lfu_cache_lru_tiebreak_top.sv =====
// Top level of the LFU key-value cache with LRU tie-break.
//
//   channel  dir  beat contents                              handshake
//   in_ch    in   operation, key, write_value                valid/ready
//   out_ch   out  hit, read_value, evicted, evicted_key      valid/ready
//   cfg_ch   in   capacity (data)                            valid/ready, ready tied high
//
// Each request runs in order: an accept in the idle state, a scan that reads one entry per
// cycle from the single-read-port entry memory through its registered read, and a commit
// that writes the entry and loads the result, held until the result register is free.
// Reset clears the valid bits, occupancy and the control state; no clearing pass runs.
// A result waits in its own register, so the next request is taken while it is pending;
// commit of that next request holds until the result register is free.
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_top import lfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lfu_in_if.sink    in_ch,
  lfu_out_if.source out_ch,
  lfu_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  res_t      res;
  logic      out_valid;

  assign cfg_ch.ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfu_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_ch.operation),
    .in_key         (in_ch.key),
    .in_write_value (in_ch.write_value),
    .cfg_wr         (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ch.ready),
    .out_res        (res)
  );

  // Result beat onto the output channel
  assign out_ch.valid       = out_valid;
  assign out_ch.hit         = res.hit;
  assign out_ch.read_value  = res.read_value;
  assign out_ch.evicted     = res.evicted;
  assign out_ch.evicted_key = res.evicted_key;

endmodule
